// ===== sv/ssba_pkg.sv =====
// Shared types, constants and helpers for the swap slot bitmap allocator.
package ssba_pkg;

  // Field widths fixed by the interface
  localparam int SLOT_IN_W  = 16;
  localparam int SLOT_OUT_W = 12;
  localparam int ADDR_W     = 48;
  localparam int STATUS_W   = 3;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 1;

  // Bitmap word organization
  localparam int WORD_W = 64;
  localparam int BIT_W  = 6;

  // Defaults for top-level parameters
  localparam int SLOTS_DEF            = 4096;
  localparam int SECTORS_PER_SLOT_DEF = 8;

  localparam logic [ADDR_W-1:0] BASE_RESET = 48'd409600;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DISK_PRESENT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_BLOCK   = 1'd1;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_LOCATE = 2'd1,
    OP_FREE   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_DISK   = 3'd1,
    ST_FULL      = 3'd2,
    ST_XFER_FAIL = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_ADDR,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } zsrch_t;

  // Lowest clear bit of a bitmap word
  function automatic zsrch_t first_zero(input logic [WORD_W-1:0] w);
    zsrch_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r.found = 1'b1;
        r.idx   = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/ssba_bitmap_mem.sv =====
// Bitmap word store: one write port, one read port with registered data.
module ssba_bitmap_mem import ssba_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [WORD_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/ssba_addr_unit.sv =====
// Block address unit: base + slot * sectors per slot, two register stages.
module ssba_addr_unit import ssba_pkg::*; #(
  parameter int SECTORS_PER_SLOT = SECTORS_PER_SLOT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [SLOT_IN_W-1:0] slot,
  input  logic [ADDR_W-1:0]    base,
  output logic                 done,
  output logic [ADDR_W-1:0]    addr
);

  localparam int PROD_W = SLOT_IN_W + $clog2(SECTORS_PER_SLOT + 1);

  logic              v1_r, v1_nxt;
  logic              v2_r, v2_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [ADDR_W-1:0] sum_r, sum_nxt;

  // stage 1 multiply, stage 2 add (wraps at the address width)
  always_comb begin
    v1_nxt   = start;
    v2_nxt   = v1_r;
    prod_nxt = start ? PROD_W'(slot) * PROD_W'(SECTORS_PER_SLOT) : prod_r;
    sum_nxt  = v1_r ? base + ADDR_W'(prod_r) : sum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    sum_r  <= sum_nxt;
  end

  assign done = v2_r;
  assign addr = sum_r;

endmodule

// ===== sv/swap_slot_bitmap_allocator.sv =====
// Swap slot bitmap allocator top: request sequencer, config and result register.
//
//   channel  | ports                                     | direction
//   ---------+-------------------------------------------+----------
//   in       | in_valid in_stall in_op in_slot in_disk_ok | request
//   out      | out_valid out_stall out_status out_slot_out out_block_addr | result
//   cfg      | cfg_we cfg_idx cfg_wdata                  | register write
//
// After reset a clearing pass writes every bitmap word, with in_stall high.
// Allocate scans the bitmap one 64-bit word per cycle, up to every word of the
// map; locate waits on the address unit, free reads and rewrites one word, and
// early errors go straight to the result state.
// The scan over the single-port read of the bitmap memory sets the rate.
// One request is in work at a time; the result register lets the next
// request be accepted while a result waits on out_stall.
module swap_slot_bitmap_allocator import ssba_pkg::*; #(
  parameter int SLOTS            = SLOTS_DEF,
  parameter int SECTORS_PER_SLOT = SECTORS_PER_SLOT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_op,
  input  logic [SLOT_IN_W-1:0]  in_slot,
  input  logic                  in_disk_ok,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [SLOT_OUT_W-1:0] out_slot_out,
  output logic [ADDR_W-1:0]     out_block_addr,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ADDR_W-1:0]     cfg_wdata
);

  localparam int NWORDS    = (SLOTS + WORD_W - 1) / WORD_W;
  localparam int WIDX_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int LAST_BITS = SLOTS - (NWORDS - 1) * WORD_W;
  localparam logic [WIDX_W-1:0] LAST_IDX = WIDX_W'(NWORDS - 1);
  localparam logic [WORD_W-1:0] LAST_MASK =
    WORD_W'(((WORD_W + 1)'(1) << LAST_BITS) - (WORD_W + 1)'(1));

  // configuration registers
  logic              disk_present_r;
  logic [ADDR_W-1:0] base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_present_r <= 1'b0;
      base_r         <= BASE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DISK_PRESENT: disk_present_r <= cfg_wdata[0];
        REG_BASE_BLOCK:   base_r         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer state
  state_t                state_r, state_nxt;
  logic [WIDX_W-1:0]     idx_r, idx_nxt;
  logic                  ok_r, ok_nxt;
  logic [SLOT_IN_W-1:0]  slot_r, slot_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [SLOT_OUT_W-1:0] res_slot_r, res_slot_nxt;
  logic                  res_addr_en_r, res_addr_en_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;
  logic [ADDR_W-1:0]     out_addr_r, out_addr_nxt;

  // memory and address unit hookup
  logic              mem_rd_en;
  logic [WIDX_W-1:0] mem_rd_addr;
  logic [WORD_W-1:0] mem_rd_data;
  logic              mem_wr_en;
  logic [WIDX_W-1:0] mem_wr_addr;
  logic [WORD_W-1:0] mem_wr_data;

  logic                 addr_start;
  logic [SLOT_IN_W-1:0] addr_slot;
  logic                 addr_done;
  logic [ADDR_W-1:0]    addr_val;

  logic                 accept;
  logic                 in_range;
  logic [WORD_W-1:0]    pad;
  zsrch_t               srch;
  logic [SLOT_IN_W-1:0] found_slot;

  ssba_bitmap_mem #(
    .DEPTH (NWORDS),
    .AW    (WIDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  ssba_addr_unit #(
    .SECTORS_PER_SLOT (SECTORS_PER_SLOT)
  ) u_addr (
    .clk   (clk),
    .rst_n (rst_n),
    .start (addr_start),
    .slot  (addr_slot),
    .base  (base_r),
    .done  (addr_done),
    .addr  (addr_val)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_range = ({1'b0, in_slot} < (SLOT_IN_W + 1)'(SLOTS));

  // slots past SLOTS in the last word count as used
  assign pad        = (idx_r == LAST_IDX) ? ~LAST_MASK : '0;
  assign srch       = first_zero(mem_rd_data | pad);
  assign found_slot = (SLOT_IN_W'(idx_r) << BIT_W) | SLOT_IN_W'(srch.idx);

  // next state and datapath control
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    ok_nxt          = ok_r;
    slot_nxt        = slot_r;
    res_status_nxt  = res_status_r;
    res_slot_nxt    = res_slot_r;
    res_addr_en_nxt = res_addr_en_r;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = idx_r;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = idx_r;
    mem_wr_data     = '0;
    addr_start      = 1'b0;
    addr_slot       = slot_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    out_addr_nxt    = out_addr_r;

    case (state_r)
      // zero one bitmap word per cycle
      S_CLEAR: begin
        mem_wr_en = 1'b1;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (accept) begin
          ok_nxt          = in_disk_ok;
          slot_nxt        = in_slot;
          res_addr_en_nxt = 1'b0;
          res_slot_nxt    = '0;
          state_nxt       = S_RESULT;
          case (op_t'(in_op))
            OP_ALLOC: begin
              if (!disk_present_r) begin
                res_status_nxt = ST_NO_DISK;
              end else begin
                idx_nxt     = '0;
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
                state_nxt   = S_SCAN;
              end
            end
            OP_LOCATE: begin
              if (!disk_present_r) begin
                res_status_nxt = ST_NO_DISK;
              end else if (!in_range) begin
                res_status_nxt = ST_RANGE;
                res_slot_nxt   = in_slot[SLOT_OUT_W-1:0];
              end else begin
                addr_start      = 1'b1;
                addr_slot       = in_slot;
                res_slot_nxt    = in_slot[SLOT_OUT_W-1:0];
                res_status_nxt  = in_disk_ok ? ST_OK : ST_XFER_FAIL;
                res_addr_en_nxt = 1'b1;
                state_nxt       = S_ADDR;
              end
            end
            OP_FREE: begin
              res_slot_nxt = in_slot[SLOT_OUT_W-1:0];
              if (!in_range) begin
                res_status_nxt = ST_RANGE;
              end else begin
                res_status_nxt = ST_OK;
                mem_rd_en      = 1'b1;
                mem_rd_addr    = WIDX_W'(in_slot >> BIT_W);
                state_nxt      = S_FREE;
              end
            end
            default: begin
              res_status_nxt = ST_RANGE;
            end
          endcase
        end
      end

      // examine the word read last cycle, else fetch the next one
      S_SCAN: begin
        if (srch.found) begin
          addr_start      = 1'b1;
          addr_slot       = found_slot;
          res_slot_nxt    = found_slot[SLOT_OUT_W-1:0];
          res_status_nxt  = ok_r ? ST_OK : ST_XFER_FAIL;
          res_addr_en_nxt = 1'b1;
          mem_wr_en       = ok_r;
          mem_wr_data     = mem_rd_data | (WORD_W'(1) << srch.idx);
          state_nxt       = S_ADDR;
        end else if (idx_r == LAST_IDX) begin
          res_status_nxt = ST_FULL;
          res_slot_nxt   = '0;
          state_nxt      = S_RESULT;
        end else begin
          idx_nxt     = idx_r + 1'b1;
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_r + 1'b1;
        end
      end

      // clear the slot's bit in the fetched word
      S_FREE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = WIDX_W'(slot_r >> BIT_W);
        mem_wr_data = mem_rd_data & ~(WORD_W'(1) << slot_r[BIT_W-1:0]);
        state_nxt   = S_RESULT;
      end

      S_ADDR: begin
        if (addr_done) begin
          state_nxt = S_RESULT;
        end
      end

      // hand the item to the result register once it is free
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_addr_nxt   = res_addr_en_r ? addr_val : '0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ok_r          <= ok_nxt;
    slot_r        <= slot_nxt;
    res_status_r  <= res_status_nxt;
    res_slot_r    <= res_slot_nxt;
    res_addr_en_r <= res_addr_en_nxt;
    out_status_r  <= out_status_nxt;
    out_slot_r    <= out_slot_nxt;
    out_addr_r    <= out_addr_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_out   = out_slot_r;
  assign out_block_addr = out_addr_r;

  // no request is taken during the clearing pass
  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> in_stall)
    else $error("request accepted during bitmap clear");

  // an accepted request always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("sequencer stayed idle after accepting a request");

  // the bitmap is never written while idle
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (state_r != S_IDLE))
    else $error("bitmap written while idle");

  // address results only land while the sequencer waits for them
  a_addr_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    addr_done |-> (state_r == S_ADDR))
    else $error("address unit finished outside the wait state");

  // a result is loaded only from the result state
  a_load_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && !(out_valid_r && out_stall)) |-> (state_r == S_RESULT))
    else $error("result register loaded outside the result state");

endmodule
